/* hw/rtl/sharp_pkg.sv */
package sharp_pkg;

    localparam int ROW_W              = 12;
    localparam int COL_W              = 11;
    localparam int CFG_W              = 12;
    localparam int CFG_IDX_W          = 2;
    localparam int PIX_W              = 24;
    localparam int MAX_LINE_WIDTH_DEF = 2048;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] FRAME_ROWS_RST = 12'd480;
    localparam logic [CFG_W-1:0] FRAME_COLS_RST = 12'd640;

    // bit positions in the emit mask, A leaves first
    localparam int EMIT_A = 3;  // (r-1, c-1)
    localparam int EMIT_B = 2;  // (r-1, c)
    localparam int EMIT_C = 1;  // (r,   c-1)
    localparam int EMIT_D = 0;  // (r,   c)

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_ROWS = 2'd0,
        REG_FRAME_COLS = 2'd1
    } sharp_reg_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } sharp_in_t;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             run_last;
    } sharp_out_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic [3:0]       emit;
        rgb_t             px_a;
        rgb_t             px_b;
        rgb_t             px_c;
        rgb_t             px_d;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } sharp_entry_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } sharp_qstat_t;

endpackage

/* hw/rtl/sharpen_conv3x3_rgb.sv */
// 3x3 sharpening filter for a 24-bit RGB pixel stream in raster order.
// s_valid/s_ready/s_data take one pixel per transfer; m_valid/m_ready/m_data
// give result pixels with their row and column, in raster order, lagging the
// input by one row and one column. run_last marks the last result released by
// one input pixel: none for most of the first row, two at the end of a row, up
// to four for the last pixel of the frame. cfg_valid/cfg_index/cfg_data write
// frame_rows (index 0) and frame_cols (index 1); cfg_ready is always high and
// writes are meant only while the block is idle.
// The first result of an input passes the s1 registers, a queue slot,
// the current-entry register and the output register. Throughput: one pixel
// per clock while m_ready is high and each input releases at most one result;
// the result port moves one result per clock. One line store read and one
// write per cycle keep the input side at a pixel per clock.
// A 4-entry queue parts the front from the result side: when m_ready is low the
// queue fills and s_ready drops once no slot is left for a pixel in flight.
// Reset: position at row 0, column 0, frame size 480 x 640, queue and output
// empty. The line stores are not cleared; their contents are only used once
// the rows above have been written.
module sharpen_conv3x3_rgb #(
    parameter int MAX_LINE_WIDTH = sharp_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  sharp_pkg::sharp_in_t            s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output sharp_pkg::sharp_out_t           m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sharp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sharp_pkg::CFG_W-1:0]     cfg_data
);

    logic                    push;
    logic                    pop;
    sharp_pkg::sharp_entry_t push_entry;
    sharp_pkg::sharp_entry_t head;
    sharp_pkg::sharp_qstat_t q_stat;

    assign cfg_ready = 1'b1;

    sharp_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_entry(push_entry)
    );

    sharp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    sharp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_stat.count < sharp_pkg::QCNT_W'(sharp_pkg::QUEUE_DEPTH)))
        else $error("queue written while full");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_stat.count == sharp_pkg::QCNT_W'(sharp_pkg::QUEUE_DEPTH)) |-> !s_ready)
        else $error("input ready with queue full");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.run_last) |=> m_valid)
        else $error("gap inside a run of results");

endmodule

/* hw/rtl/sharp_front.sv */
module sharp_front #(
    parameter int MAX_LINE_WIDTH = sharp_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  sharp_pkg::sharp_in_t           s_data,
    input  logic                           cfg_valid,
    input  logic [sharp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sharp_pkg::CFG_W-1:0]    cfg_data,
    input  sharp_pkg::sharp_qstat_t        q_stat,
    output logic                           push,
    output sharp_pkg::sharp_entry_t        push_entry
);

    localparam int CW  = $clog2(MAX_LINE_WIDTH);
    localparam int CLW = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMW = (CLW > sharp_pkg::CFG_W) ? CLW : sharp_pkg::CFG_W;
    localparam int LW  = 2 * sharp_pkg::PIX_W;
    localparam logic [CMW-1:0] MAX_COLS = CMW'(MAX_LINE_WIDTH);

    function automatic logic [7:0] sharpen_chan(input logic [7:0] c, input logic [7:0] n,
                                                input logic [7:0] s, input logic [7:0] w,
                                                input logic [7:0] e);
        logic signed [11:0] acc;
        logic [7:0]         res;
        acc = $signed({2'b0, c, 2'b0}) + $signed({4'b0, c}) - $signed({4'b0, n})
            - $signed({4'b0, s}) - $signed({4'b0, w}) - $signed({4'b0, e});
        if (acc < 0) begin
            res = 8'd0;
        end else if (acc > 12'sd255) begin
            res = 8'd255;
        end else begin
            res = acc[7:0];
        end
        return res;
    endfunction

    logic [sharp_pkg::CFG_W-1:0] frame_rows_reg;
    logic [sharp_pkg::CFG_W-1:0] frame_cols_reg;
    logic [sharp_pkg::ROW_W-1:0] row_reg;
    logic [CW-1:0]               col_reg;

    logic [sharp_pkg::ROW_W-1:0] erows;
    logic [CMW-1:0]              cols_w;
    logic [CLW-1:0]              ecols;
    logic                        restart;
    logic [sharp_pkg::ROW_W-1:0] cur_row;
    logic [CW-1:0]               cur_col;
    logic                        last_row;
    logic                        last_col;
    logic [sharp_pkg::ROW_W-1:0] row_next;
    logic [CW-1:0]               col_next;
    logic                        accept;
    logic [3:0]                  emit_next;
    logic                        interior_next;
    sharp_pkg::rgb_t             px_in;

    logic                        s1_valid_reg;
    sharp_pkg::rgb_t             s1_px_reg;
    logic [CW-1:0]               s1_col_reg;
    logic [sharp_pkg::ROW_W-1:0] s1_row_reg;
    logic [3:0]                  s1_emit_reg;
    logic                        s1_interior_reg;
    logic                        byp_hit_reg;
    logic [LW-1:0]               byp_data_reg;
    logic [LW-1:0]               rd_reg;

    logic [LW-1:0]               line_mem [MAX_LINE_WIDTH];
    logic [LW-1:0]               line_word;
    sharp_pkg::rgb_t             s1_up;
    sharp_pkg::rgb_t             s1_mid;

    sharp_pkg::rgb_t             w02_reg;
    sharp_pkg::rgb_t             w11_reg;
    sharp_pkg::rgb_t             w12_reg;
    sharp_pkg::rgb_t             w22_reg;
    sharp_pkg::rgb_t             sharp_px;

    // frame registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= sharp_pkg::FRAME_ROWS_RST;
            frame_cols_reg <= sharp_pkg::FRAME_COLS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                sharp_pkg::REG_FRAME_ROWS: frame_rows_reg <= cfg_data;
                sharp_pkg::REG_FRAME_COLS: frame_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective frame size and position of the incoming pixel
    always_comb begin
        erows = (frame_rows_reg == '0) ? sharp_pkg::ROW_W'(1) : frame_rows_reg;
        cols_w = CMW'(frame_cols_reg);
        if (cols_w == '0) begin
            cols_w = CMW'(1);
        end else if (cols_w > MAX_COLS) begin
            cols_w = MAX_COLS;
        end
        ecols = cols_w[CLW-1:0];

        restart  = (row_reg >= erows) || (CLW'(col_reg) >= ecols);
        cur_row  = restart ? '0 : row_reg;
        cur_col  = restart ? '0 : col_reg;
        last_row = (cur_row == erows - sharp_pkg::ROW_W'(1));
        last_col = (CLW'(cur_col) == ecols - CLW'(1));

        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : cur_row + sharp_pkg::ROW_W'(1);
        end else begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end

        emit_next                    = '0;
        emit_next[sharp_pkg::EMIT_A] = (cur_row != '0) && (cur_col != '0);
        emit_next[sharp_pkg::EMIT_B] = (cur_row != '0) && last_col;
        emit_next[sharp_pkg::EMIT_C] = last_row && (cur_col != '0);
        emit_next[sharp_pkg::EMIT_D] = last_row && last_col;
        interior_next = (cur_row >= sharp_pkg::ROW_W'(2)) && (cur_col >= CW'(2));

        px_in.red   = s_data.in_red;
        px_in.green = s_data.in_green;
        px_in.blue  = s_data.in_blue;
    end

    // one slot per pixel in flight: reserve queue room before taking it
    assign s_ready = ({1'b0, q_stat.count} + (sharp_pkg::QCNT_W + 1)'(s1_valid_reg))
                     < (sharp_pkg::QCNT_W + 1)'(sharp_pkg::QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg       <= px_in;
            s1_col_reg      <= cur_col;
            s1_row_reg      <= cur_row;
            s1_emit_reg     <= emit_next;
            s1_interior_reg <= interior_next;
            // the store write of the pixel ahead lands in this same cycle
            byp_hit_reg     <= s1_valid_reg && (s1_col_reg == cur_col);
            byp_data_reg    <= {s1_mid, s1_px_reg};
        end
    end

    // line store: {upper, middle} per column
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= line_mem[cur_col];
        end
        if (s1_valid_reg) begin
            line_mem[s1_col_reg] <= {s1_mid, s1_px_reg};
        end
    end

    assign line_word = byp_hit_reg ? byp_data_reg : rd_reg;
    assign s1_up     = line_word[LW-1:sharp_pkg::PIX_W];
    assign s1_mid    = line_word[sharp_pkg::PIX_W-1:0];

    // window: only the taps that are still read after the shift
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            w11_reg <= w12_reg;
            w02_reg <= s1_up;
            w12_reg <= s1_mid;
            w22_reg <= s1_px_reg;
        end
    end

    always_comb begin
        sharp_px.red   = sharpen_chan(w12_reg.red, w02_reg.red, w22_reg.red,
                                      w11_reg.red, s1_mid.red);
        sharp_px.green = sharpen_chan(w12_reg.green, w02_reg.green, w22_reg.green,
                                      w11_reg.green, s1_mid.green);
        sharp_px.blue  = sharpen_chan(w12_reg.blue, w02_reg.blue, w22_reg.blue,
                                      w11_reg.blue, s1_mid.blue);

        push_entry.emit = s1_emit_reg;
        push_entry.px_a = s1_interior_reg ? sharp_px : w12_reg;
        push_entry.px_b = s1_mid;
        push_entry.px_c = w22_reg;
        push_entry.px_d = s1_px_reg;
        push_entry.row  = s1_row_reg;
        push_entry.col  = sharp_pkg::COL_W'(s1_col_reg);
    end

    assign push = s1_valid_reg && (s1_emit_reg != '0);

endmodule

/* hw/rtl/sharp_fifo.sv */
module sharp_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  sharp_pkg::sharp_entry_t push_entry,
    input  logic                    pop,
    output sharp_pkg::sharp_entry_t head,
    output sharp_pkg::sharp_qstat_t q_stat
);

    sharp_pkg::sharp_entry_t            slot_reg [sharp_pkg::QUEUE_DEPTH];
    logic [sharp_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sharp_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sharp_pkg::QCNT_W-1:0]       count_reg;
    logic [sharp_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [sharp_pkg::QPTR_W-1:0]       rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == sharp_pkg::QPTR_W'(sharp_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_reg + sharp_pkg::QPTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == sharp_pkg::QPTR_W'(sharp_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_reg + sharp_pkg::QPTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + sharp_pkg::QCNT_W'(1);
                2'b01:   count_reg <= count_reg - sharp_pkg::QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign q_stat.valid = (count_reg != '0);
    assign q_stat.count = count_reg;

endmodule

/* hw/rtl/sharp_back.sv */
module sharp_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sharp_pkg::sharp_qstat_t q_stat,
    input  sharp_pkg::sharp_entry_t head,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sharp_pkg::sharp_out_t   m_data
);

    sharp_pkg::sharp_entry_t     cur_reg;
    logic                        cur_valid_reg;
    logic                        m_valid_reg;
    sharp_pkg::sharp_out_t       m_data_reg;

    logic [3:0]                  rest;
    sharp_pkg::rgb_t             res_px;
    logic [sharp_pkg::ROW_W-1:0] res_row;
    logic [sharp_pkg::COL_W-1:0] res_col;
    logic                        last;
    logic                        load_out;

    // pick the next pending result of the current entry, raster order
    always_comb begin
        rest    = cur_reg.emit;
        res_px  = cur_reg.px_d;
        res_row = cur_reg.row;
        res_col = cur_reg.col;
        if (cur_reg.emit[sharp_pkg::EMIT_A]) begin
            rest[sharp_pkg::EMIT_A] = 1'b0;
            res_px  = cur_reg.px_a;
            res_row = cur_reg.row - sharp_pkg::ROW_W'(1);
            res_col = cur_reg.col - sharp_pkg::COL_W'(1);
        end else if (cur_reg.emit[sharp_pkg::EMIT_B]) begin
            rest[sharp_pkg::EMIT_B] = 1'b0;
            res_px  = cur_reg.px_b;
            res_row = cur_reg.row - sharp_pkg::ROW_W'(1);
        end else if (cur_reg.emit[sharp_pkg::EMIT_C]) begin
            rest[sharp_pkg::EMIT_C] = 1'b0;
            res_px  = cur_reg.px_c;
            res_col = cur_reg.col - sharp_pkg::COL_W'(1);
        end else begin
            rest[sharp_pkg::EMIT_D] = 1'b0;
        end
        last = (rest == '0);
    end

    assign load_out = cur_valid_reg && (!m_valid_reg || m_ready);
    assign pop      = q_stat.valid && (!cur_valid_reg || (load_out && last));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                cur_valid_reg <= 1'b1;
            end else if (load_out && last) begin
                cur_valid_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head;
        end else if (load_out) begin
            cur_reg.emit <= rest;
        end
        if (load_out) begin
            m_data_reg.out_red   <= res_px.red;
            m_data_reg.out_green <= res_px.green;
            m_data_reg.out_blue  <= res_px.blue;
            m_data_reg.out_row   <= res_row;
            m_data_reg.out_col   <= res_col;
            m_data_reg.run_last  <= last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
